// ===== design/websocket_frame_deframer_core_assert.svh =====
// assertion macros for the frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define WSDF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsdf check failed");
`define WSDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsdf check failed");
`else
`define WSDF_ASSERT_NOW(label, clk, rst, ante, cons)
`define WSDF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/wsdf_pkg.sv =====
package wsdf_pkg;

  localparam int MAX_LEN_BITS = 31;
  localparam int LEN_W        = MAX_LEN_BITS;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_PAY
  } phase_t;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [2:0] KIND_TEXT    = 3'd0;
  localparam logic [2:0] KIND_PING    = 3'd1;
  localparam logic [2:0] KIND_CLOSE   = 3'd2;
  localparam logic [2:0] KIND_ERROR   = 3'd3;
  localparam logic [2:0] KIND_ABANDON = 3'd4;

  localparam logic [1:0] ERR_TOO_LARGE  = 2'd0;
  localparam logic [1:0] ERR_UNEXP_CONT = 2'd1;
  localparam logic [1:0] ERR_BAD_OPCODE = 2'd2;

  localparam logic [1:0] FRAG_NONE = 2'd0;
  localparam logic [1:0] FRAG_TEXT = 2'd1;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic [2:0] kind;
    logic       stream_sel;
    logic       msg_start;
    logic       last;
    logic [1:0] error_code;
  } res_t;

endpackage

// ===== design/wsdf_if.sv =====
interface wsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       data_valid;
  logic [2:0] kind;
  logic       stream_sel;
  logic       msg_start;
  logic       last;
  logic [1:0] error_code;

  modport source (
    output valid, output data, output data_valid, output kind, output stream_sel,
    output msg_start, output last, output error_code, input ready
  );
  modport sink (
    input valid, input data, input data_valid, input kind, input stream_sel,
    input msg_start, input last, input error_code, output ready
  );
endinterface

// ===== design/websocket_frame_deframer_core.sv =====
// each result word is registered into the result queue as its byte is accepted
// throughput: one byte per cycle while the queue has room; the parser step is a single registered pass
// a two-word result queue keeps input flowing while one result waits to be taken
// input stalls only when both queue words are held
// reset (synchronous, rst high) returns the parser to the first header byte and empties the queue
`include "websocket_frame_deframer_core_assert.svh"

module websocket_frame_deframer_core (
  input logic       clk,
  input logic       rst,
  wsdf_in_if.sink   frames,
  wsdf_out_if.source results
);
  import wsdf_pkg::*;

  phase_t            phase, phase_next;
  logic              fin, fin_next;
  logic [3:0]        opcode, opcode_next;
  logic              masked, masked_next;
  logic [3:0]        ext_left, ext_left_next;
  logic [LEN_W-1:0]  len, len_next;
  logic              ovf, ovf_next;
  logic [31:0]       mask_key, mask_key_next;
  logic [1:0]        mask_pos, mask_pos_next;
  logic [LEN_W-1:0]  pay_left, pay_left_next;
  logic [1:0]        pend_type, pend_type_next;
  logic              pend_started, pend_started_next;
  logic              stopped, stopped_next;

  logic              acc;
  logic [7:0]        b;
  logic              hdr_done;
  logic              del;
  logic              have;
  logic [7:0]        dbyte;
  logic              first;
  logic              fend;
  logic              emit;
  res_t              res_new;

  res_t              q0, q1, q0_next, q1_next;
  logic              q0_valid, q1_valid, q0_valid_next, q1_valid_next;
  logic              pop;

  assign b   = frames.rx_byte;
  assign acc = frames.valid && frames.ready;
  assign frames.ready = !q1_valid;

  always_comb begin
    phase_next        = phase;
    fin_next          = fin;
    opcode_next       = opcode;
    masked_next       = masked;
    ext_left_next     = ext_left;
    len_next          = len;
    ovf_next          = ovf;
    mask_key_next     = mask_key;
    mask_pos_next     = mask_pos;
    pay_left_next     = pay_left;
    pend_type_next    = pend_type;
    pend_started_next = pend_started;
    stopped_next      = stopped;
    hdr_done          = 1'b0;
    del               = 1'b0;
    have              = 1'b0;
    dbyte             = 8'd0;
    first             = 1'b0;
    fend              = 1'b0;
    emit              = 1'b0;
    res_new           = '0;

    if (!stopped) begin
      case (phase)
        PH_HDR0: begin
          fin_next    = b[7];
          opcode_next = b[3:0];
          masked_next = 1'b0;
          phase_next  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_next   = b[7];
          mask_key_next = '0;
          mask_pos_next = '0;
          len_next      = '0;
          ovf_next      = 1'b0;
          if (b[6:0] == LEN_CODE_16) begin
            ext_left_next = EXT_BYTES_16;
            phase_next    = PH_EXT;
          end else if (b[6:0] == LEN_CODE_64) begin
            ext_left_next = EXT_BYTES_64;
            phase_next    = PH_EXT;
          end else begin
            len_next = LEN_W'(b[6:0]);
            if (b[7]) begin
              phase_next = PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_EXT: begin
          len_next      = {len[LEN_W-9:0], b};
          ovf_next      = ovf || (len[LEN_W-1 -: 8] != 8'd0);
          ext_left_next = ext_left - 4'd1;
          if (ext_left_next == 4'd0) begin
            if (masked) begin
              phase_next = PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], b};
          mask_pos_next = mask_pos + 2'd1;
          if (mask_pos_next == 2'd0) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAY: begin
          case (mask_pos)
            2'd0:    dbyte = b ^ mask_key[31:24];
            2'd1:    dbyte = b ^ mask_key[23:16];
            2'd2:    dbyte = b ^ mask_key[15:8];
            default: dbyte = b ^ mask_key[7:0];
          endcase
          first         = (pay_left == len);
          mask_pos_next = mask_pos + 2'd1;
          pay_left_next = pay_left - LEN_W'(1);
          fend          = (pay_left_next == '0);
          if (fend) begin
            phase_next = PH_HDR0;
          end
          have = 1'b1;
          del  = 1'b1;
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      // header complete
      if (hdr_done) begin
        if (ovf_next) begin
          stopped_next       = 1'b1;
          phase_next         = PH_HDR0;
          emit               = 1'b1;
          res_new.kind       = KIND_ERROR;
          res_new.error_code = ERR_TOO_LARGE;
        end else begin
          pay_left_next = len_next;
          mask_pos_next = '0;
          phase_next    = PH_PAY;
          if ((opcode == OP_TEXT || opcode == OP_BIN) && !fin) begin
            if (pend_type == FRAG_TEXT && pend_started) begin
              emit         = 1'b1;
              res_new.kind = KIND_ABANDON;
            end
            pend_type_next    = opcode[1:0];
            pend_started_next = 1'b0;
          end
          if (len_next == '0) begin
            phase_next = PH_HDR0;
            if (!emit) begin
              del   = 1'b1;
              first = 1'b1;
              fend  = 1'b1;
            end
          end
        end
      end

      // payload delivery by opcode
      if (del) begin
        case (opcode)
          OP_CONT: begin
            if (pend_type_next == FRAG_NONE) begin
              if (fend) begin
                stopped_next       = 1'b1;
                phase_next         = PH_HDR0;
                emit               = 1'b1;
                res_new.kind       = KIND_ERROR;
                res_new.error_code = ERR_UNEXP_CONT;
              end
            end else if (pend_type_next == FRAG_TEXT) begin
              if (have || (fend && fin)) begin
                emit               = 1'b1;
                res_new.data       = have ? dbyte : 8'd0;
                res_new.data_valid = have;
                res_new.kind       = KIND_TEXT;
                res_new.stream_sel = 1'b1;
                res_new.msg_start  = !pend_started_next;
                res_new.last       = fend && fin;
                pend_started_next  = 1'b1;
                if (fend && fin) begin
                  pend_type_next    = FRAG_NONE;
                  pend_started_next = 1'b0;
                end
              end
            end else if (fend && fin) begin
              pend_type_next    = FRAG_NONE;
              pend_started_next = 1'b0;
            end
          end
          OP_TEXT: begin
            if (fin) begin
              emit               = 1'b1;
              res_new.data       = have ? dbyte : 8'd0;
              res_new.data_valid = have;
              res_new.kind       = KIND_TEXT;
              res_new.msg_start  = first;
              res_new.last       = fend;
            end else if (have) begin
              emit               = 1'b1;
              res_new.data       = dbyte;
              res_new.data_valid = 1'b1;
              res_new.kind       = KIND_TEXT;
              res_new.stream_sel = 1'b1;
              res_new.msg_start  = !pend_started_next;
              pend_started_next  = 1'b1;
            end
          end
          OP_BIN, OP_PONG: begin
          end
          OP_CLOSE: begin
            if (fend) begin
              stopped_next = 1'b1;
              phase_next   = PH_HDR0;
              emit         = 1'b1;
              res_new.kind = KIND_CLOSE;
            end
          end
          OP_PING: begin
            emit               = 1'b1;
            res_new.data       = have ? dbyte : 8'd0;
            res_new.data_valid = have;
            res_new.kind       = KIND_PING;
            res_new.msg_start  = first;
            res_new.last       = fend;
          end
          default: begin
            if (fend) begin
              stopped_next       = 1'b1;
              phase_next         = PH_HDR0;
              emit               = 1'b1;
              res_new.kind       = KIND_ERROR;
              res_new.error_code = ERR_BAD_OPCODE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      fin          <= 1'b0;
      opcode       <= '0;
      masked       <= 1'b0;
      ext_left     <= '0;
      len          <= '0;
      ovf          <= 1'b0;
      mask_key     <= '0;
      mask_pos     <= '0;
      pay_left     <= '0;
      pend_type    <= FRAG_NONE;
      pend_started <= 1'b0;
      stopped      <= 1'b0;
    end else if (acc) begin
      phase        <= phase_next;
      fin          <= fin_next;
      opcode       <= opcode_next;
      masked       <= masked_next;
      ext_left     <= ext_left_next;
      len          <= len_next;
      ovf          <= ovf_next;
      mask_key     <= mask_key_next;
      mask_pos     <= mask_pos_next;
      pay_left     <= pay_left_next;
      pend_type    <= pend_type_next;
      pend_started <= pend_started_next;
      stopped      <= stopped_next;
    end
  end

  // two-word result queue
  assign pop = results.valid && results.ready;

  always_comb begin
    q0_next       = q0;
    q1_next       = q1;
    q0_valid_next = q0_valid;
    q1_valid_next = q1_valid;
    if (pop) begin
      q0_next       = q1;
      q0_valid_next = q1_valid;
      q1_valid_next = 1'b0;
    end
    if (acc && emit) begin
      if (!q0_valid_next) begin
        q0_next       = res_new;
        q0_valid_next = 1'b1;
      end else begin
        q1_next       = res_new;
        q1_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q0_valid <= 1'b0;
      q1_valid <= 1'b0;
    end else begin
      q0_valid <= q0_valid_next;
      q1_valid <= q1_valid_next;
    end
    q0 <= q0_next;
    q1 <= q1_next;
  end

  assign results.valid      = q0_valid;
  assign results.data       = q0.data;
  assign results.data_valid = q0.data_valid;
  assign results.kind       = q0.kind;
  assign results.stream_sel = q0.stream_sel;
  assign results.msg_start  = q0.msg_start;
  assign results.last       = q0.last;
  assign results.error_code = q0.error_code;

  `WSDF_ASSERT_NEXT(a_stopped_sticky, clk, rst, stopped, stopped)
  `WSDF_ASSERT_NOW(a_queue_order, clk, rst, q1_valid, q0_valid)
  `WSDF_ASSERT_NOW(a_no_result_when_stopped, clk, rst, acc && stopped, !emit)
  `WSDF_ASSERT_NOW(a_payload_nonzero, clk, rst, phase == PH_PAY, pay_left != '0)
  `WSDF_ASSERT_NEXT(a_halt_result, clk, rst, acc && !stopped && stopped_next,
                    q0_valid && (q1_valid || results.kind == KIND_ERROR ||
                    results.kind == KIND_CLOSE))

endmodule
